// ===== design/mke_pkg.sv =====
// mke_pkg: shared types, codes, glyph table and microcode rom for the morse keying encoder
// no dependencies; used by mke_sequencer and morse_keying_encoder_core
package mke_pkg;

    localparam int DIT_W      = 20;
    localparam int DUR_W      = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_DIT_US        = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FINAL_TONE_US = 1'd1;

    localparam logic [DIT_W-1:0] DIT_US_RESET        = 20'd60000;
    localparam logic [DUR_W-1:0] FINAL_TONE_US_RESET = 24'd1000000;

    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [5:0] DIGIT_BASE   = 6'd26;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic             key_on;
        logic [DUR_W-1:0] duration_us;
        logic             last_of_run;
    } out_t;

    // element count and dash mask, bit i set for a dash at element i
    typedef struct packed {
        logic [2:0] len;
        logic [4:0] dash;
    } glyph_t;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_GLYPH,
        CLS_SPACE
    } class_t;

    typedef enum logic [2:0] {
        STEP_FETCH,
        STEP_ELEM_ON,
        STEP_ELEM_OFF,
        STEP_EOT,
        STEP_SPACE
    } step_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_ALWAYS,
        EMIT_IF_EOT
    } emit_t;

    typedef enum logic [1:0] {
        DUR_ELEM,
        DUR_GAP,
        DUR_SPACE,
        DUR_FINAL
    } dur_t;

    typedef enum logic [1:0] {
        LAST_NEVER,
        LAST_FINAL_NO_EOT,
        LAST_NO_EOT,
        LAST_ALWAYS
    } last_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_CLASS,
        JMP_MORE,
        JMP_ALWAYS
    } jmp_t;

    typedef struct packed {
        logic  fetch;
        emit_t emit;
        logic  key_on;
        dur_t  dur_sel;
        last_t last_cond;
        jmp_t  jmp;
        step_t target;
    } uword_t;

    typedef struct packed {
        logic   in_valid;
        class_t cls;
        logic   more;
        logic   eot;
        logic   out_free;
    } seq_status_t;

    typedef struct packed {
        step_t  step;
        uword_t word;
        logic   emit_active;
        logic   advance;
    } seq_ctl_t;

    function automatic uword_t ucode_rom(input step_t step);
        uword_t w;
        case (step)
            STEP_FETCH:    w = '{1'b1, EMIT_NONE,   1'b0, DUR_ELEM,  LAST_NEVER,
                                 JMP_CLASS,  STEP_FETCH};
            STEP_ELEM_ON:  w = '{1'b0, EMIT_ALWAYS, 1'b1, DUR_ELEM,  LAST_NEVER,
                                 JMP_NEXT,   STEP_FETCH};
            STEP_ELEM_OFF: w = '{1'b0, EMIT_ALWAYS, 1'b0, DUR_GAP,   LAST_FINAL_NO_EOT,
                                 JMP_MORE,   STEP_ELEM_ON};
            STEP_EOT:      w = '{1'b0, EMIT_IF_EOT, 1'b1, DUR_FINAL, LAST_ALWAYS,
                                 JMP_ALWAYS, STEP_FETCH};
            STEP_SPACE:    w = '{1'b0, EMIT_ALWAYS, 1'b0, DUR_SPACE, LAST_NO_EOT,
                                 JMP_ALWAYS, STEP_EOT};
            default:       w = '{1'b0, EMIT_NONE,   1'b0, DUR_ELEM,  LAST_NEVER,
                                 JMP_ALWAYS, STEP_FETCH};
        endcase
        return w;
    endfunction

    // letters a..z then digits 0..9
    function automatic glyph_t glyph_rom(input logic [5:0] sel);
        glyph_t g;
        case (sel)
            6'd0:  g = '{3'd2, 5'b00010};
            6'd1:  g = '{3'd4, 5'b00001};
            6'd2:  g = '{3'd4, 5'b00101};
            6'd3:  g = '{3'd3, 5'b00001};
            6'd4:  g = '{3'd1, 5'b00000};
            6'd5:  g = '{3'd4, 5'b00100};
            6'd6:  g = '{3'd3, 5'b00011};
            6'd7:  g = '{3'd4, 5'b00000};
            6'd8:  g = '{3'd2, 5'b00000};
            6'd9:  g = '{3'd4, 5'b01110};
            6'd10: g = '{3'd3, 5'b00101};
            6'd11: g = '{3'd4, 5'b00010};
            6'd12: g = '{3'd2, 5'b00011};
            6'd13: g = '{3'd2, 5'b00001};
            6'd14: g = '{3'd3, 5'b00111};
            6'd15: g = '{3'd4, 5'b00110};
            6'd16: g = '{3'd4, 5'b01011};
            6'd17: g = '{3'd3, 5'b00010};
            6'd18: g = '{3'd3, 5'b00000};
            6'd19: g = '{3'd1, 5'b00001};
            6'd20: g = '{3'd3, 5'b00100};
            6'd21: g = '{3'd4, 5'b01000};
            6'd22: g = '{3'd3, 5'b00110};
            6'd23: g = '{3'd4, 5'b01001};
            6'd24: g = '{3'd4, 5'b01101};
            6'd25: g = '{3'd4, 5'b00011};
            6'd26: g = '{3'd5, 5'b11111};
            6'd27: g = '{3'd5, 5'b11110};
            6'd28: g = '{3'd5, 5'b11100};
            6'd29: g = '{3'd5, 5'b11000};
            6'd30: g = '{3'd5, 5'b10000};
            6'd31: g = '{3'd5, 5'b00000};
            6'd32: g = '{3'd5, 5'b00001};
            6'd33: g = '{3'd5, 5'b00011};
            6'd34: g = '{3'd5, 5'b00111};
            6'd35: g = '{3'd5, 5'b01111};
            default: g = '{3'd1, 5'b00000};
        endcase
        return g;
    endfunction

endpackage

// ===== design/mke_sequencer.sv =====
// mke_sequencer: step counter, microcode lookup and jump logic
// depends on mke_pkg (uword_t, seq_status_t, seq_ctl_t, ucode_rom)
module mke_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  mke_pkg::seq_status_t status,
    output mke_pkg::seq_ctl_t    ctl
);

    mke_pkg::step_t  pc_reg;
    mke_pkg::step_t  pc_next;
    mke_pkg::uword_t word;
    logic            emit_active;
    logic            advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= mke_pkg::STEP_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    always_comb
    begin
        word = mke_pkg::ucode_rom(pc_reg);

        case (word.emit)
            mke_pkg::EMIT_ALWAYS: emit_active = 1'b1;
            mke_pkg::EMIT_IF_EOT: emit_active = status.eot;
            default:              emit_active = 1'b0;
        endcase

        if (word.fetch)
        begin
            advance = status.in_valid;
        end
        else if (emit_active)
        begin
            advance = status.out_free;
        end
        else
        begin
            advance = 1'b1;
        end

        pc_next = pc_reg;
        if (advance)
        begin
            case (word.jmp)
                mke_pkg::JMP_CLASS:
                begin
                    case (status.cls)
                        mke_pkg::CLS_GLYPH: pc_next = mke_pkg::STEP_ELEM_ON;
                        mke_pkg::CLS_SPACE: pc_next = mke_pkg::STEP_SPACE;
                        default:            pc_next = mke_pkg::STEP_EOT;
                    endcase
                end
                mke_pkg::JMP_MORE:
                begin
                    pc_next = status.more ? word.target : mke_pkg::step_t'(pc_reg + 3'd1);
                end
                mke_pkg::JMP_ALWAYS: pc_next = word.target;
                default:             pc_next = mke_pkg::step_t'(pc_reg + 3'd1);
            endcase
        end

        ctl.step        = pc_reg;
        ctl.word        = word;
        ctl.emit_active = emit_active;
        ctl.advance     = advance;
    end

endmodule

// ===== design/morse_keying_encoder_core.sv =====
// morse_keying_encoder_core: top level, character in, keying segments out
// depends on mke_pkg and mke_sequencer
//
//   channel | direction | handshake           | payload
//   in      | into      | in_valid / in_stall  | in_data  (mke_pkg::in_t)
//   out     | out of    | out_valid / out_stall| out_data (mke_pkg::out_t)
//   cfg     | into      | cfg_we               | cfg_index, cfg_data
//
// the fetch step takes the request; a glyph then runs an on and an off step per element,
// a space runs the space step, and every request closes with the end-of-text step
// a new request is taken only at the fetch step
// reset clears the step counter, output valid and both registers to their defaults
// a stalled output holds the sequencer on its emitting step; the input is stalled meanwhile
module morse_keying_encoder_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  mke_pkg::in_t                        in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output mke_pkg::out_t                       out_data,
    input  logic                                cfg_we,
    input  logic [mke_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mke_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [mke_pkg::DIT_W-1:0] dit_reg;
    logic [mke_pkg::DUR_W-1:0] final_reg;

    logic       eot_reg;
    logic [2:0] len_reg;
    logic [4:0] dash_reg;
    logic [2:0] elem_reg;

    logic          out_valid_reg;
    mke_pkg::out_t out_reg;
    mke_pkg::out_t seg;

    mke_pkg::seq_status_t status;
    mke_pkg::seq_ctl_t    ctl;

    mke_pkg::class_t cls;
    logic [5:0]      sel;
    mke_pkg::glyph_t glyph;
    logic            accept_in;
    logic            final_elem;
    logic            load;

    logic [mke_pkg::DUR_W-1:0] dit_x1;
    logic [mke_pkg::DUR_W-1:0] dit_x2;
    logic [mke_pkg::DUR_W-1:0] dit_x3;
    logic [mke_pkg::DUR_W-1:0] dit_x8;

    mke_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctl    (ctl)
    );

    // character classification
    always_comb
    begin
        cls = mke_pkg::CLS_NONE;
        sel = 6'd0;
        if (in_data.char_code inside {[mke_pkg::CHAR_LOWER_A:mke_pkg::CHAR_LOWER_Z]})
        begin
            cls = mke_pkg::CLS_GLYPH;
            sel = 6'(in_data.char_code - mke_pkg::CHAR_LOWER_A);
        end
        else if (in_data.char_code inside {[mke_pkg::CHAR_ZERO:mke_pkg::CHAR_NINE]})
        begin
            cls = mke_pkg::CLS_GLYPH;
            sel = 6'(in_data.char_code - mke_pkg::CHAR_ZERO) + mke_pkg::DIGIT_BASE;
        end
        else if (in_data.char_code == mke_pkg::CHAR_SPACE)
        begin
            cls = mke_pkg::CLS_SPACE;
        end
        glyph = mke_pkg::glyph_rom(sel);
    end

    assign in_stall   = !ctl.word.fetch;
    assign accept_in  = in_valid && !in_stall;
    assign final_elem = (elem_reg == (len_reg - 3'd1));

    assign status.in_valid = in_valid;
    assign status.cls      = cls;
    assign status.more     = !final_elem;
    assign status.eot      = eot_reg;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign load = ctl.emit_active && ctl.advance;

    // dit multiples by shift and add
    assign dit_x1 = mke_pkg::DUR_W'(dit_reg);
    assign dit_x2 = {dit_x1[mke_pkg::DUR_W-2:0], 1'b0};
    assign dit_x3 = dit_x2 + dit_x1;
    assign dit_x8 = {dit_x1[mke_pkg::DUR_W-4:0], 3'b000};

    always_comb
    begin
        seg.key_on = ctl.word.key_on;
        case (ctl.word.dur_sel)
            mke_pkg::DUR_ELEM:  seg.duration_us = dash_reg[elem_reg] ? dit_x3 : dit_x1;
            mke_pkg::DUR_GAP:   seg.duration_us = dit_x2;
            mke_pkg::DUR_SPACE: seg.duration_us = dit_x8;
            default:            seg.duration_us = final_reg;
        endcase
        case (ctl.word.last_cond)
            mke_pkg::LAST_FINAL_NO_EOT: seg.last_of_run = !eot_reg && final_elem;
            mke_pkg::LAST_NO_EOT:       seg.last_of_run = !eot_reg;
            mke_pkg::LAST_ALWAYS:       seg.last_of_run = 1'b1;
            default:                    seg.last_of_run = 1'b0;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dit_reg   <= mke_pkg::DIT_US_RESET;
            final_reg <= mke_pkg::FINAL_TONE_US_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == mke_pkg::REG_DIT_US)
            begin
                dit_reg <= cfg_data[mke_pkg::DIT_W-1:0];
            end
            if (cfg_index == mke_pkg::REG_FINAL_TONE_US)
            begin
                final_reg <= cfg_data[mke_pkg::DUR_W-1:0];
            end
        end
    end

    // request latch and element counter
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            eot_reg  <= in_data.end_of_text;
            len_reg  <= glyph.len;
            dash_reg <= glyph.dash;
            elem_reg <= 3'd0;
        end
        else if (ctl.advance && (ctl.step == mke_pkg::STEP_ELEM_OFF))
        begin
            elem_reg <= elem_reg + 3'd1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= seg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_accept_leaves_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> in_stall)
        else $error("sequencer still at fetch after taking a request");

    a_elem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((ctl.step == mke_pkg::STEP_ELEM_ON) || (ctl.step == mke_pkg::STEP_ELEM_OFF))
        |-> (elem_reg < len_reg))
        else $error("element counter past glyph length");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (load && seg.last_of_run) |=> !load)
        else $error("segment emitted after the last of a run");

endmodule
